[hdl/assert_macros.svh]
// shared assertion macros, empty when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/bdc_pkg.sv]
`timescale 1ns / 1ps
package bdc_pkg;
    localparam int COORD_W         = 32;
    localparam int DEG_W           = 2;
    localparam int NUM_PTS         = 4;
    localparam int T_FRAC_BITS_DEF = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DEG_W-1:0]          deg_t;
endpackage

[hdl/bezier_de_casteljau_eval.sv]
`timescale 1ns / 1ps
// channel  | handshake          | words
// ---------+--------------------+-------------------------------------------------
// input    | s_valid / s_ready  | s_degree, s_param_t, s_point0 .. s_point3
// result   | m_valid / m_ready  | m_curve_value
//
// one word in and one word out per cycle while m_ready is high; the path is an input
// register, then a multiply stage and a round stage for each of the three levels
// aresetn is synchronous and active low, it clears the valid bits only
// each stage holds its word while the next is full, so a stall on m_ready
// backs up stage by stage and no word is dropped or repeated
`include "assert_macros.svh"
module bezier_de_casteljau_eval #(
    parameter int T_FRAC_BITS = bdc_pkg::T_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bdc_pkg::deg_t         s_degree,
    input  logic [T_FRAC_BITS:0]  s_param_t,
    input  bdc_pkg::coord_t       s_point0,
    input  bdc_pkg::coord_t       s_point1,
    input  bdc_pkg::coord_t       s_point2,
    input  bdc_pkg::coord_t       s_point3,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bdc_pkg::coord_t       m_curve_value
);
    import bdc_pkg::*;

    localparam int TW = T_FRAC_BITS + 1;
    // 1.0 in the t format
    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    // input register, t is clamped to 1.0 here
    logic           st0_valid_reg;
    logic           st0_ready;
    deg_t           st0_degree_reg;
    logic [TW-1:0]  st0_t_reg;
    logic [TW-1:0]  st0_t_next;
    coord_t         st0_pts_reg [NUM_PTS];

    // level to level links
    logic           l1_valid, l1_ready;
    deg_t           l1_degree;
    logic [TW-1:0]  l1_t;
    coord_t         l1_pts [NUM_PTS-1];
    logic           l2_valid, l2_ready;
    deg_t           l2_degree;
    logic [TW-1:0]  l2_t;
    coord_t         l2_pts [NUM_PTS-2];
    coord_t         l3_pts [NUM_PTS-3];

    assign st0_t_next = (s_param_t > T_ONE) ? T_ONE : s_param_t;
    assign s_ready    = st0_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (st0_ready) begin
            st0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (st0_ready && s_valid) begin
            st0_degree_reg <= s_degree;
            st0_t_reg      <= st0_t_next;
            st0_pts_reg[0] <= s_point0;
            st0_pts_reg[1] <= s_point1;
            st0_pts_reg[2] <= s_point2;
            st0_pts_reg[3] <= s_point3;
        end
    end

    // level 1: four controls to three blends
    bdc_level #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (1),
        .N_IN        (NUM_PTS)
    ) u_level1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (st0_valid_reg),
        .in_ready   (st0_ready),
        .in_degree  (st0_degree_reg),
        .in_t       (st0_t_reg),
        .in_pts     (st0_pts_reg),
        .out_valid  (l1_valid),
        .out_ready  (l1_ready),
        .out_degree (l1_degree),
        .out_t      (l1_t),
        .out_pts    (l1_pts)
    );

    // level 2: three to two
    bdc_level #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (2),
        .N_IN        (NUM_PTS-1)
    ) u_level2 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (l1_valid),
        .in_ready   (l1_ready),
        .in_degree  (l1_degree),
        .in_t       (l1_t),
        .in_pts     (l1_pts),
        .out_valid  (l2_valid),
        .out_ready  (l2_ready),
        .out_degree (l2_degree),
        .out_t      (l2_t),
        .out_pts    (l2_pts)
    );

    // level 3: two to one, its round stage is the output register
    bdc_level #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .LEVEL       (3),
        .N_IN        (NUM_PTS-2)
    ) u_level3 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (l2_valid),
        .in_ready   (l2_ready),
        .in_degree  (l2_degree),
        .in_t       (l2_t),
        .in_pts     (l2_pts),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_degree (),
        .out_t      (),
        .out_pts    (l3_pts)
    );

    assign m_curve_value = l3_pts[0];

    // clamp keeps t at or below 1.0 inside the pipe
    `ASSERT_ALWAYS(a_t_clamped, aclk, aresetn, !st0_valid_reg || (st0_t_reg <= T_ONE))
    // a free sink means every stage can advance, so the input is open
    `ASSERT_ALWAYS(a_ready_chain, aclk, aresetn, !m_ready || s_ready)
    // a stalled input stage keeps its word
    `ASSERT_NEXT(a_st0_hold, aclk, aresetn, st0_valid_reg && !st0_ready,
        st0_valid_reg && $stable(st0_t_reg) && $stable(st0_degree_reg))
endmodule

[hdl/bdc_level.sv]
`timescale 1ns / 1ps
// one de casteljau level: multiply stage, then round and add stage
module bdc_level #(
    parameter int T_FRAC_BITS = bdc_pkg::T_FRAC_BITS_DEF,
    parameter int LEVEL       = 1,
    parameter int N_IN        = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bdc_pkg::deg_t         in_degree,
    input  logic [T_FRAC_BITS:0]  in_t,
    input  bdc_pkg::coord_t       in_pts [N_IN],
    output logic                  out_valid,
    input  logic                  out_ready,
    output bdc_pkg::deg_t         out_degree,
    output logic [T_FRAC_BITS:0]  out_t,
    output bdc_pkg::coord_t       out_pts [N_IN-1]
);
    import bdc_pkg::*;

    localparam int N_OUT = N_IN - 1;
    localparam int TW    = T_FRAC_BITS + 1;
    localparam int DW    = COORD_W + 1;
    localparam int PW    = DW + TW + 1;
    localparam deg_t LEVEL_CODE = DEG_W'(LEVEL);
    localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << (T_FRAC_BITS - 1));

    // multiply stage
    logic                   a_valid_reg;
    logic                   a_ready;
    logic                   a_act_reg;
    deg_t                   a_degree_reg;
    logic [TW-1:0]          a_t_reg;
    coord_t                 a_base_reg [N_OUT];
    logic signed [PW-1:0]   a_prod_reg [N_OUT];
    logic signed [PW-1:0]   a_prod_next [N_OUT];
    logic signed [DW-1:0]   a_diff [N_OUT];
    logic signed [TW:0]     a_t_s;

    // round and add stage
    logic                   b_valid_reg;
    logic                   b_ready;
    coord_t                 b_pts_reg [N_OUT];
    coord_t                 b_pts_next [N_OUT];
    deg_t                   b_degree_reg;
    logic [TW-1:0]          b_t_reg;
    logic signed [PW-1:0]   b_rnd [N_OUT];
    logic signed [PW-1:0]   b_shift [N_OUT];
    logic signed [DW-1:0]   b_sum [N_OUT];

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // t times (b - a), the (1-t)*a term folds into the base
    always_comb begin
        a_t_s = $signed({1'b0, in_t});
        for (int i = 0; i < N_OUT; i++) begin
            a_diff[i]      = $signed({in_pts[i+1][COORD_W-1], in_pts[i+1]})
                           - $signed({in_pts[i][COORD_W-1], in_pts[i]});
            a_prod_next[i] = PW'(a_diff[i]) * PW'(a_t_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_act_reg    <= (LEVEL_CODE <= in_degree);
            a_degree_reg <= in_degree;
            a_t_reg      <= in_t;
            for (int i = 0; i < N_OUT; i++) begin
                a_base_reg[i] <= in_pts[i];
                a_prod_reg[i] <= a_prod_next[i];
            end
        end
    end

    // levels past the degree pass their elements through unchanged
    always_comb begin
        for (int i = 0; i < N_OUT; i++) begin
            b_rnd[i]   = a_prod_reg[i] + RND_HALF;
            b_shift[i] = b_rnd[i] >>> T_FRAC_BITS;
            b_sum[i]   = $signed({a_base_reg[i][COORD_W-1], a_base_reg[i]})
                       + $signed(b_shift[i][DW-1:0]);
            b_pts_next[i] = a_act_reg ? $signed(b_sum[i][COORD_W-1:0]) : a_base_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_degree_reg <= a_degree_reg;
            b_t_reg      <= a_t_reg;
            for (int i = 0; i < N_OUT; i++) begin
                b_pts_reg[i] <= b_pts_next[i];
            end
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_degree = b_degree_reg;
    assign out_t      = b_t_reg;
    always_comb begin
        for (int i = 0; i < N_OUT; i++) begin
            out_pts[i] = b_pts_reg[i];
        end
    end
endmodule
